// ===== rtl/sorted_table_interpolation_search_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_INTERPOLATION_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_INTERPOLATION_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define STIS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stis check failed");

// next-cycle implication
`define STIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stis check failed");

`endif

// ===== rtl/stis_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search: package
// Sizes, beat types, mode codes and sequencer states.
// ---------------------------------------------------------------------------
package stis_pkg;

	localparam int DEPTH  = 1024;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int SIZE_W = IDX_W + 1;
	localparam int DATA_W = 32;
	localparam int NUM_W  = DATA_W + IDX_W;
	localparam int PTR_W  = IDX_W + 2;
	localparam int CNT_W  = $clog2(IDX_W);

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] search_key;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_index;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ENDS,
		ST_MUL,
		ST_DIV,
		ST_PROBE,
		ST_PCMP
	} state_t;

endpackage

// ===== rtl/stis_ram.sv =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search: table memory
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module stis_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/stis_div.sv =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search: probe divider
// Restoring divider, one quotient bit per cycle; quotient fits the index.
// ---------------------------------------------------------------------------
module stis_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stis_pkg::NUM_W-1:0]  num,
	input  logic [stis_pkg::DATA_W-1:0] den,
	output logic                        done,
	output logic [stis_pkg::IDX_W-1:0]  quo
);

	import stis_pkg::*;

	localparam int DSH_W = DATA_W + IDX_W - 1;

	logic             act_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [IDX_W-1:0] quo_q;
	logic [NUM_W-1:0] dsh_ext;
	logic             ge;

	assign dsh_ext = {{(NUM_W-DSH_W){1'b0}}, dsh_q};
	assign ge      = rem_q >= dsh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(IDX_W - 1)) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {(IDX_W-1){1'b0}}};
		end else if (act_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_ext;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[IDX_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/sorted_table_interpolation_search_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search unit
// Holds a 1024-entry table of signed 32-bit values, written in ascending
// order, and searches it by linear interpolation.
// Command channel: a beat is taken at a clock edge with start high and busy
// low. Mode write stores entry_value at entry_index in that cycle; busy does
// not rise and no result follows. Mode search raises busy and yields exactly
// one result beat: done high for one cycle with result valid. The receiver
// cannot stall; the result must be taken in that cycle.
// Each probe reads the table ends, multiplies, divides in the restoring
// divider and reads the probe entry, all on the one table memory. Uniform
// data needs few probes, the worst case at most table_size probes.
// Configuration: table_size is written on the cfg channel (always ready);
// the user must write it only while no search runs, which the block does
// not enforce. Values above 1024 act as 1024, zero means empty.
// Reset clears table_size, the sequencer and the result strobe; the table
// itself holds no defined contents until written.
// ---------------------------------------------------------------------------
module sorted_table_interpolation_search_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  stis_pkg::cmd_t              cmd,
	output logic                        done,
	output stis_pkg::res_t              result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [stis_pkg::SIZE_W-1:0] cfg_data
);

	import stis_pkg::*;

	state_t                   state_q, state_d;
	logic [SIZE_W-1:0]        size_q;
	logic                     done_q;
	res_t                     res_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [PTR_W-1:0]  lo_q, hi_q;
	logic [DATA_W-1:0]        kdiff_q, den_q;
	logic [IDX_W-1:0]         span_q;
	logic [IDX_W-1:0]         pos_q;

	logic                     accept, take_search, take_write;
	logic [SIZE_W-1:0]        tbl_n;
	logic signed [PTR_W-1:0]  hi_init;
	logic                     empty;
	logic [DATA_W-1:0]        ram_a, ram_b;
	logic signed [DATA_W-1:0] t_lo, t_hi;
	logic                     out_range, lo_eq_hi, ends_eq;
	logic signed [DATA_W:0]   kd_w, dn_w;
	logic signed [PTR_W-1:0]  span_w, pos_ext;
	logic [NUM_W-1:0]         prod;
	logic                     div_start, div_done;
	logic [IDX_W-1:0]         quo;
	logic [IDX_W-1:0]         raddr_a;
	logic                     fin, fin_found;
	logic [IDX_W-1:0]         fin_idx;

	assign accept      = start && !busy;
	assign take_search = accept && (cmd.mode == MODE_SEARCH);
	assign take_write  = accept && (cmd.mode == MODE_WRITE);

	assign tbl_n   = (size_q > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : size_q;
	assign hi_init = $signed({1'b0, tbl_n}) - PTR_W'(1);
	assign empty   = lo_q > hi_q;

	assign t_lo      = $signed(ram_a);
	assign t_hi      = $signed(ram_b);
	assign out_range = (key_q < t_lo) || (key_q > t_hi);
	assign lo_eq_hi  = lo_q == hi_q;
	assign ends_eq   = t_lo == t_hi;
	assign kd_w      = {key_q[DATA_W-1], key_q} - {t_lo[DATA_W-1], t_lo};
	assign dn_w      = {t_hi[DATA_W-1], t_hi} - {t_lo[DATA_W-1], t_lo};
	assign span_w    = hi_q - lo_q;
	assign prod      = NUM_W'(kdiff_q) * NUM_W'(span_q);
	assign pos_ext   = $signed({2'b00, pos_q});

	stis_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (take_write),
		.waddr   (cmd.entry_index),
		.wdata   (cmd.entry_value),
		.raddr_a (raddr_a),
		.rdata_a (ram_a),
		.raddr_b (hi_q[IDX_W-1:0]),
		.rdata_b (ram_b)
	);

	stis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take_search) state_d = ST_CHECK;
			ST_CHECK: state_d = empty ? ST_IDLE : ST_ENDS;
			ST_ENDS:  state_d = (out_range || lo_eq_hi || ends_eq) ? ST_IDLE : ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_PROBE;
			ST_PROBE: state_d = ST_PCMP;
			ST_PCMP:  state_d = (t_lo == key_q) ? ST_IDLE : ST_CHECK;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and finish decode
	always_comb begin
		busy      = state_q != ST_IDLE;
		div_start = state_q == ST_MUL;
		raddr_a   = (state_q == ST_PROBE) ? pos_q : lo_q[IDX_W-1:0];
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_idx   = lo_q[IDX_W-1:0];
		case (state_q)
			ST_CHECK: fin = empty;
			ST_ENDS: begin
				if (out_range) begin
					fin = 1'b1;
				end else if (lo_eq_hi) begin
					fin       = 1'b1;
					fin_found = t_lo == key_q;
				end else if (ends_eq) begin
					fin       = 1'b1;
					fin_found = 1'b1;
				end
			end
			ST_PCMP: begin
				fin       = t_lo == key_q;
				fin_found = fin;
				fin_idx   = pos_q;
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_search) begin
			key_q <= cmd.search_key;
			lo_q  <= '0;
			hi_q  <= hi_init;
		end
		if (state_q == ST_ENDS) begin
			kdiff_q <= kd_w[DATA_W-1:0];
			den_q   <= dn_w[DATA_W-1:0];
			span_q  <= span_w[IDX_W-1:0];
		end
		if (state_q == ST_DIV && div_done) begin
			pos_q <= lo_q[IDX_W-1:0] + quo;
		end
		// narrow the window around the probe
		if (state_q == ST_PCMP && t_lo != key_q) begin
			if (t_lo < key_q) begin
				lo_q <= pos_ext + PTR_W'(1);
			end else begin
				hi_q <= pos_ext - PTR_W'(1);
			end
		end
		if (fin) begin
			res_q.found       <= fin_found;
			res_q.found_index <= fin_found ? fin_idx : '0;
		end
	end

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

endmodule

// ===== rtl/stis_checker.sv =====
// ---------------------------------------------------------------------------
// Sorted table interpolation search: port checker
// Watches the command and result beats of the top level over time.
// ---------------------------------------------------------------------------
`include "sorted_table_interpolation_search_unit_defines.svh"

module stis_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input stis_pkg::cmd_t cmd,
	input logic           done,
	input stis_pkg::res_t result
);

	import stis_pkg::*;

	`STIS_ASSERT_SAME(a_done_after_busy, done, $past(busy))
	`STIS_ASSERT_SAME(a_miss_index_zero, done && !result.found, result.found_index == '0)
	`STIS_ASSERT_NEXT(a_search_goes_busy, start && !busy && cmd.mode == MODE_SEARCH, busy)
	`STIS_ASSERT_NEXT(a_write_no_beat, start && !busy && cmd.mode == MODE_WRITE, !busy && !done)
	`STIS_ASSERT_NEXT(a_single_beat, done, !done)

endmodule

bind sorted_table_interpolation_search_unit stis_checker u_stis_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// ===== dv/sorted_table_interpolation_search_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted table interpolation search unit: self-checking testbench
// Loads sorted, skewed, duplicate-heavy and unsorted tables of many sizes,
// sets table_size between phases and fires searches at present, absent and
// out-of-range keys. Each result beat is compared with a local interpolation
// lookup over a shadow copy of the table. Sender gaps run at 34%, then 67%,
// then none.
// ---------------------------------------------------------------------------
module sorted_table_interpolation_search_unit_tb;
	import stis_pkg::*;

	localparam int          RANDOM_ITEMS  = 250;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          CYCLE_LIMIT   = 2_000_000;
	localparam int          VAL_MIN       = 32'sh8000_0000;
	localparam int          VAL_MAX       = 32'sh7fff_ffff;

	typedef enum logic [1:0] {BEAT_CMD, BEAT_SIZE, BEAT_SETTLE} beat_kind_t;
	typedef enum int {
		SHAPE_UNIFORM, SHAPE_RANDOM, SHAPE_DUPS, SHAPE_SKEWED, SHAPE_SPAN, SHAPE_UNSORTED
	} shape_t;

	typedef struct {
		beat_kind_t        kind;
		cmd_t              cmd;
		logic [SIZE_W-1:0] size;
		int unsigned       gap_pct;
	} beat_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	cmd_t              cmd       = '0;
	logic              done;
	res_t              result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data  = '0;

	beat_t                    beats_to_send [$];
	res_t                     answers_due [$];
	logic signed [DATA_W-1:0] table_model [DEPTH];
	logic [SIZE_W-1:0]        size_model = '0;
	int                       plan_tbl [DEPTH];
	int                       plan_size;
	int                       items_planned;
	logic                     cmd_taken = 1'b0;
	logic                     cfg_taken = 1'b0;
	int                       settle_wait;
	int                       error_count;
	int                       writes_taken;
	int                       searches_checked;
	int                       hits;
	int                       sizes_set;
	int                       cycles;

	sorted_table_interpolation_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic note_error(string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	function automatic res_t interp_lookup(logic signed [DATA_W-1:0] key);
		res_t                     ans;
		int                       n;
		int                       lo;
		int                       hi;
		int                       pos;
		logic                     searching;
		logic signed [DATA_W-1:0] tlo;
		logic signed [DATA_W-1:0] thi;
		ans       = '0;
		n         = (size_model > DEPTH) ? DEPTH : int'(size_model);
		lo        = 0;
		hi        = n - 1;
		searching = 1'b1;
		while (searching && lo <= hi) begin
			tlo = table_model[lo];
			thi = table_model[hi];
			if (key < tlo || key > thi) begin
				searching = 1'b0;
			end else if (lo == hi || thi == tlo) begin
				// equal ends: key must equal t[lo]
				if (tlo == key) begin
					ans.found       = 1'b1;
					ans.found_index = IDX_W'(lo);
				end
				searching = 1'b0;
			end else begin
				pos = lo + int'(((longint'(key) - longint'(tlo)) * longint'(hi - lo)) /
					(longint'(thi) - longint'(tlo)));
				if (table_model[pos] == key) begin
					ans.found       = 1'b1;
					ans.found_index = IDX_W'(pos);
					searching       = 1'b0;
				end else if (table_model[pos] < key) begin
					lo = pos + 1;
				end else begin
					hi = pos - 1;
				end
			end
		end
		return ans;
	endfunction

	task automatic push_write(int idx, int val, int unsigned gap);
		beat_t b;
		b.kind              = BEAT_CMD;
		b.cmd.mode          = MODE_WRITE;
		b.cmd.entry_index   = IDX_W'(idx);
		b.cmd.entry_value   = val;
		b.cmd.search_key    = $urandom;
		b.size              = '0;
		b.gap_pct           = gap;
		beats_to_send.push_back(b);
		plan_tbl[idx] = val;
		items_planned++;
	endtask

	task automatic push_search(int key, int unsigned gap);
		beat_t b;
		b.kind              = BEAT_CMD;
		b.cmd.mode          = MODE_SEARCH;
		b.cmd.entry_index   = IDX_W'($urandom);
		b.cmd.entry_value   = $urandom;
		b.cmd.search_key    = key;
		b.size              = '0;
		b.gap_pct           = gap;
		beats_to_send.push_back(b);
		items_planned++;
	endtask

	// drain all searches, then write table_size
	task automatic push_size(int size, int unsigned gap);
		beat_t b;
		b.kind    = BEAT_SETTLE;
		b.cmd     = '0;
		b.size    = '0;
		b.gap_pct = 0;
		beats_to_send.push_back(b);
		b.kind    = BEAT_SIZE;
		b.size    = SIZE_W'(size);
		b.gap_pct = gap;
		beats_to_send.push_back(b);
		plan_size = (size > DEPTH) ? DEPTH : size;
	endtask

	function automatic int pick_key(int n);
		int r;
		r = $urandom_range(0, 99);
		if (n == 0 || r >= 85)
			return $urandom;
		if (r < 55)
			return plan_tbl[$urandom_range(0, n - 1)];
		if (r < 70)
			return plan_tbl[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
		if (r < 78)
			return $urandom_range(0, 1) ? VAL_MIN : plan_tbl[0] - 1;
		return $urandom_range(0, 1) ? VAL_MAX : plan_tbl[n - 1] + 1;
	endfunction

	task automatic add_random_set(int unsigned gap);
		int     r;
		int     n;
		int     vals [64];
		longint acc;
		longint step;
		longint inc;
		shape_t shape;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			push_size($urandom_range(0, 1) ? $urandom_range(1024, 2047) : DEPTH, gap);
			repeat (3) push_search(pick_key(plan_size), gap);
			return;
		end
		n     = (r < 8) ? 0 : (r < 20) ? $urandom_range(1, 3) : $urandom_range(4, 40);
		shape = shape_t'($urandom_range(0, 5));
		acc   = (shape == SHAPE_SPAN) ? longint'(VAL_MIN) : longint'(int'($urandom));
		step  = (shape == SHAPE_UNIFORM) ? $urandom_range(1, 1 << $urandom_range(0, 20)) : 1;
		for (int i = 0; i < n; i++) begin
			case (shape)
				SHAPE_UNIFORM:  inc = step;
				SHAPE_RANDOM:   inc = $urandom_range(0, 1 << $urandom_range(0, 24));
				SHAPE_DUPS:     inc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
				SHAPE_SKEWED: begin
					inc  = step;
					step = step * 2 + $urandom_range(0, 1);
				end
				SHAPE_SPAN:     inc = longint'($urandom) % (2 * (64'd4294967295 / n) + 1);
				default:        inc = 0;
			endcase
			if (i != 0)
				acc += inc;
			if (acc > VAL_MAX)
				acc = VAL_MAX;
			vals[i] = (shape == SHAPE_UNSORTED) ? int'($urandom) : int'(acc);
		end
		if (shape == SHAPE_SPAN && n >= 2) begin
			vals[0]     = VAL_MIN;
			vals[n - 1] = VAL_MAX;
		end
		push_size(n, gap);
		for (int i = 0; i < n; i++)
			push_write(i, vals[i], gap);
		if ($urandom_range(0, 3) == 0)
			push_write($urandom_range(n, DEPTH - 1), $urandom, gap);
		repeat ($urandom_range(3, 10)) push_search(pick_key(n), gap);
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		logic  go_start;
		logic  go_cfg;
		beat_t head;
		if (arst_n) begin
			go_start = start && !cmd_taken;
			go_cfg   = cfg_valid && !cfg_taken;
			if (!go_start && !go_cfg && beats_to_send.size() != 0) begin
				head = beats_to_send[0];
				if (head.kind == BEAT_SETTLE) begin
					if (answers_due.size() != 0) begin
						settle_wait = 0;
					end else if (settle_wait >= SETTLE_CYCLES) begin
						settle_wait = 0;
						head        = beats_to_send.pop_front();
					end else begin
						settle_wait++;
					end
				end else if ($urandom_range(0, 99) >= head.gap_pct) begin
					head = beats_to_send.pop_front();
					if (head.kind == BEAT_CMD) begin
						go_start = 1'b1;
						cmd <= head.cmd;
					end else begin
						go_cfg = 1'b1;
						cfg_data <= head.size;
					end
				end
			end
			start <= go_start;
			cfg_valid <= go_cfg;
		end
	end

	// monitor and predictor: sample on the rising edge
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			size_model = '0;
			cmd_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			cmd_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (done === 1'b1) begin
				if (answers_due.size() == 0) begin
					note_error("result beat with no search outstanding");
				end else begin
					want = answers_due.pop_front();
					if (result.found !== want.found)
						note_error($sformatf("found %b, expected %b", result.found, want.found));
					if (result.found_index !== want.found_index)
						note_error($sformatf("found_index %0d, expected %0d",
							result.found_index, want.found_index));
					searches_checked++;
					if (want.found)
						hits++;
				end
			end
			if (start && !busy) begin
				if (cmd.mode == MODE_WRITE) begin
					table_model[cmd.entry_index] = cmd.entry_value;
					writes_taken++;
				end else begin
					answers_due.push_back(interp_lookup(cmd.search_key));
				end
			end
			if (cfg_valid && cfg_ready) begin
				size_model = cfg_data;
				sizes_set++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sorted_table_interpolation_search_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		gap = 34;
		// empty table
		push_search(0, gap);
		push_search(VAL_MIN, gap);
		// single entry
		push_size(1, gap);
		push_write(0, 5, gap);
		push_search(5, gap);
		push_search(4, gap);
		push_search(6, gap);
		// full-range ends
		push_size(4, gap);
		push_write(0, VAL_MIN, gap);
		push_write(1, -7, gap);
		push_write(2, 9, gap);
		push_write(3, VAL_MAX, gap);
		push_search(VAL_MIN, gap);
		push_search(VAL_MAX, gap);
		push_search(9, gap);
		push_search(0, gap);
		push_search(-7, gap);
		// equal end values
		push_size(3, gap);
		push_write(0, 42, gap);
		push_write(1, 42, gap);
		push_write(2, 42, gap);
		push_search(42, gap);
		push_search(41, gap);
		// unsorted table
		push_size(4, gap);
		push_write(0, 50, gap);
		push_write(1, 10, gap);
		push_write(2, 30, gap);
		push_write(3, 60, gap);
		push_search(30, gap);

		// load every entry, then search the full table and an oversized size
		for (int i = 0; i < DEPTH; i++)
			push_write(i, VAL_MIN + i * 4194304 + int'($urandom_range(0, 4194303)), gap);
		push_size(DEPTH, gap);
		repeat (4) push_search(pick_key(DEPTH), gap);
		push_size(2047, gap);
		repeat (4) push_search(pick_key(DEPTH), gap);

		items_planned = 0;
		for (int ph = 0; ph < 3; ph++) begin
			gap = (ph == 0) ? 34 : (ph == 1) ? 67 : 0;
			while (items_planned < (ph + 1) * RANDOM_ITEMS / 3)
				add_random_set(gap);
		end

		repeat (2) @(posedge clk);
		#2 arst_n = 1'b1;

		while (beats_to_send.size() != 0 || start || cfg_valid)
			@(negedge clk);
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d table writes, %0d size settings, %0d searches (%0d hits)",
			writes_taken, sizes_set, searches_checked, hits);
		if (error_count == 0)
			$display("sorted_table_interpolation_search_unit regression: pass");
		else
			$display("sorted_table_interpolation_search_unit regression: fail");
		$finish;
	end

endmodule
